@@ rtl/apq_pkg.sv @@
// apq_pkg: shared types, constants and codes for the array priority queue
// used by the interfaces, the controller, the datapath and the top level
package apq_pkg;

   localparam int DEPTH   = 8;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int RIDX_W  = 3;
   localparam int OCC_W   = 4;

   typedef logic        [IDX_W-1:0]  idx_type;
   typedef logic        [CNT_W-1:0]  cnt_type;
   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT_REAR = 3'd0,
      OP_INSERT_DESC = 3'd1,
      OP_INSERT_ASC  = 3'd2,
      OP_DELETE_FRONT = 3'd3,
      OP_DELETE_MAX  = 3'd4,
      OP_DELETE_MIN  = 3'd5
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_DEL_FIRST,
      ST_SCAN_CHK,
      ST_SCAN_CMP,
      ST_SHIFT_CHK,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;          // capture request beat, clear result fields
      logic       rd_front;      // read entry at front
      logic       rd_prev;       // read entry at ptr-1
      logic       rd_ptr;        // read entry at ptr
      logic       wr_rear_val;   // entry[rear] <= value
      logic       wr_ptr_val;    // entry[ptr] <= value
      logic       wr_ptr_rd;     // entry[ptr] <= read data
      logic       ptr_from_rear;
      logic       ptr_from_front;
      logic       ptr_inc;
      logic       ptr_dec;
      logic       best_take;     // best <= read data, hit <= ptr
      logic       shift_begin;   // ptr <= hit, latch removed word and slot
      logic       front_adv;
      logic       rear_inc;
      logic       status_set;
      status_type status_code;
      logic       rsp_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            full;
      logic            empty;
      logic            ptr_gt_front;
      logic            ptr_lt_rear;
      logic            ins_stop;
      logic            better;
      logic            rsp_hold;
   } stat_type;

endpackage

@@ rtl/apq_if.sv @@
// apq_if: request and response channel interfaces (valid, ready, payload)
// depends on apq_pkg for field widths
interface apq_req_if;
   logic                             valid;
   logic                             ready;
   logic        [apq_pkg::OP_W-1:0]  opcode;
   logic signed [apq_pkg::WORD_W-1:0] value;

   modport source (output valid, opcode, value, input ready);
   modport sink   (input valid, opcode, value, output ready);
endinterface

interface apq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic        [apq_pkg::STAT_W-1:0] status;
   logic signed [apq_pkg::WORD_W-1:0] removed_value;
   logic        [apq_pkg::RIDX_W-1:0] removed_index;
   logic        [apq_pkg::OCC_W-1:0]  occupancy;

   modport source (output valid, status, removed_value, removed_index, occupancy,
                   input ready);
   modport sink   (input valid, status, removed_value, removed_index, occupancy,
                   output ready);
endinterface

@@ rtl/apq_ctrl.sv @@
// apq_ctrl: command sequencer for the priority queue
// depends on apq_pkg; drives apq_dp through cmd_type, reads stat_type
module apq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  apq_pkg::stat_type stat,
   output apq_pkg::cmd_type  cmd
);

   apq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status_code = apq_pkg::STATUS_DONE;
      req_ready = 1'b0;
      case (state_ff)
         apq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = apq_pkg::ST_DECODE;
            end
         end
         apq_pkg::ST_DECODE: begin
            case (stat.opcode)
               apq_pkg::OP_INSERT_REAR: begin
                  if (stat.full) begin
                     cmd.status_set  = 1'b1;
                     cmd.status_code = apq_pkg::STATUS_FULL;
                  end else begin
                     cmd.wr_rear_val = 1'b1;
                     cmd.rear_inc    = 1'b1;
                  end
                  state_in = apq_pkg::ST_DONE;
               end
               apq_pkg::OP_INSERT_DESC, apq_pkg::OP_INSERT_ASC: begin
                  if (stat.full) begin
                     cmd.status_set  = 1'b1;
                     cmd.status_code = apq_pkg::STATUS_FULL;
                     state_in = apq_pkg::ST_DONE;
                  end else begin
                     cmd.ptr_from_rear = 1'b1;
                     state_in = apq_pkg::ST_INS_CHK;
                  end
               end
               apq_pkg::OP_DELETE_FRONT, apq_pkg::OP_DELETE_MAX,
               apq_pkg::OP_DELETE_MIN: begin
                  if (stat.empty) begin
                     cmd.status_set  = 1'b1;
                     cmd.status_code = apq_pkg::STATUS_EMPTY;
                     state_in = apq_pkg::ST_DONE;
                  end else begin
                     cmd.rd_front       = 1'b1;
                     cmd.ptr_from_front = 1'b1;
                     state_in = apq_pkg::ST_DEL_FIRST;
                  end
               end
               default: begin
                  state_in = apq_pkg::ST_DONE;
               end
            endcase
         end
         apq_pkg::ST_INS_CHK: begin
            if (stat.ptr_gt_front) begin
               cmd.rd_prev = 1'b1;
               state_in = apq_pkg::ST_INS_CMP;
            end else begin
               cmd.wr_ptr_val = 1'b1;
               cmd.rear_inc   = 1'b1;
               state_in = apq_pkg::ST_DONE;
            end
         end
         apq_pkg::ST_INS_CMP: begin
            if (stat.ins_stop) begin
               cmd.wr_ptr_val = 1'b1;
               cmd.rear_inc   = 1'b1;
               state_in = apq_pkg::ST_DONE;
            end else begin
               cmd.wr_ptr_rd = 1'b1;
               cmd.ptr_dec   = 1'b1;
               state_in = apq_pkg::ST_INS_CHK;
            end
         end
         apq_pkg::ST_DEL_FIRST: begin
            cmd.best_take = 1'b1;
            cmd.ptr_inc   = 1'b1;
            state_in = apq_pkg::ST_SCAN_CHK;
         end
         apq_pkg::ST_SCAN_CHK: begin
            // delete front takes the front entry without scanning
            if (stat.opcode == apq_pkg::OP_DELETE_FRONT || !stat.ptr_lt_rear) begin
               cmd.shift_begin = 1'b1;
               state_in = apq_pkg::ST_SHIFT_CHK;
            end else begin
               cmd.rd_ptr = 1'b1;
               state_in = apq_pkg::ST_SCAN_CMP;
            end
         end
         apq_pkg::ST_SCAN_CMP: begin
            cmd.best_take = stat.better;
            cmd.ptr_inc   = 1'b1;
            state_in = apq_pkg::ST_SCAN_CHK;
         end
         apq_pkg::ST_SHIFT_CHK: begin
            if (stat.ptr_gt_front) begin
               cmd.rd_prev = 1'b1;
               state_in = apq_pkg::ST_SHIFT_WR;
            end else begin
               cmd.front_adv = 1'b1;
               state_in = apq_pkg::ST_DONE;
            end
         end
         apq_pkg::ST_SHIFT_WR: begin
            cmd.wr_ptr_rd = 1'b1;
            cmd.ptr_dec   = 1'b1;
            state_in = apq_pkg::ST_SHIFT_CHK;
         end
         apq_pkg::ST_DONE: begin
            if (!stat.rsp_hold) begin
               cmd.rsp_load = 1'b1;
               state_in = apq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = apq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/apq_dp.sv @@
// apq_dp: entry storage, pointers, compare logic and response register
// depends on apq_pkg; controlled by apq_ctrl through cmd_type
module apq_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  apq_pkg::cmd_type                  cmd,
   output apq_pkg::stat_type                 stat,
   input  logic        [apq_pkg::OP_W-1:0]   req_opcode,
   input  logic signed [apq_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic        [apq_pkg::STAT_W-1:0] rsp_status,
   output logic signed [apq_pkg::WORD_W-1:0] rsp_removed_value,
   output logic        [apq_pkg::RIDX_W-1:0] rsp_removed_index,
   output logic        [apq_pkg::OCC_W-1:0]  rsp_occupancy
);

   apq_pkg::word_type entry_mem [apq_pkg::DEPTH];

   apq_pkg::cnt_type   front_ff, rear_ff, ptr_ff, hit_ff;
   apq_pkg::cnt_type   ptr_prev;
   apq_pkg::word_type  rd_data_ff, best_ff, value_ff, rval_ff;
   logic [apq_pkg::OP_W-1:0] op_ff;
   apq_pkg::status_type status_ff;
   logic [apq_pkg::RIDX_W-1:0] ridx_ff;
   logic               rsp_valid_ff;

   logic               rd_en, wr_en;
   apq_pkg::idx_type   rd_addr, wr_addr;
   apq_pkg::word_type  wr_data;

   assign ptr_prev = ptr_ff - apq_pkg::CNT_W'(1);

   always_comb begin
      rd_en   = cmd.rd_front | cmd.rd_prev | cmd.rd_ptr;
      rd_addr = ptr_ff[apq_pkg::IDX_W-1:0];
      if (cmd.rd_front) begin
         rd_addr = front_ff[apq_pkg::IDX_W-1:0];
      end else if (cmd.rd_prev) begin
         rd_addr = ptr_prev[apq_pkg::IDX_W-1:0];
      end
      wr_en   = cmd.wr_rear_val | cmd.wr_ptr_val | cmd.wr_ptr_rd;
      wr_addr = cmd.wr_rear_val ? rear_ff[apq_pkg::IDX_W-1:0]
                                : ptr_ff[apq_pkg::IDX_W-1:0];
      wr_data = cmd.wr_ptr_rd ? rd_data_ff : value_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         value_ff <= req_value;
      end
      if (cmd.ptr_from_rear) begin
         ptr_ff <= rear_ff;
      end else if (cmd.ptr_from_front) begin
         ptr_ff <= front_ff;
      end else if (cmd.shift_begin) begin
         ptr_ff <= hit_ff;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + apq_pkg::CNT_W'(1);
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_prev;
      end
      if (cmd.best_take) begin
         best_ff <= rd_data_ff;
         hit_ff  <= ptr_ff;
      end
      if (cmd.load) begin
         status_ff <= apq_pkg::STATUS_DONE;
         rval_ff   <= '0;
         ridx_ff   <= '0;
      end else begin
         if (cmd.status_set) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.shift_begin) begin
            rval_ff <= best_ff;
            ridx_ff <= apq_pkg::RIDX_W'(hit_ff);
         end
      end
      if (cmd.rsp_load) begin
         rsp_status        <= status_ff;
         rsp_removed_value <= rval_ff;
         rsp_removed_index <= ridx_ff;
         rsp_occupancy     <= apq_pkg::OCC_W'(rear_ff - front_ff);
      end
   end

   // queue pointers and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rear_inc) begin
            rear_ff <= rear_ff + apq_pkg::CNT_W'(1);
         end
         if (cmd.front_adv) begin
            // queue drained: both pointers go back to slot 0
            if (front_ff + apq_pkg::CNT_W'(1) >= rear_ff) begin
               front_ff <= '0;
               rear_ff  <= '0;
            end else begin
               front_ff <= front_ff + apq_pkg::CNT_W'(1);
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.opcode       = op_ff;
      stat.full         = (rear_ff >= apq_pkg::CNT_W'(apq_pkg::DEPTH));
      stat.empty        = (front_ff >= rear_ff);
      stat.ptr_gt_front = (ptr_ff > front_ff);
      stat.ptr_lt_rear  = (ptr_ff < rear_ff);
      stat.ins_stop     = (op_ff == apq_pkg::OP_INSERT_DESC) ? (rd_data_ff > value_ff)
                                                             : (value_ff > rd_data_ff);
      stat.better       = (op_ff == apq_pkg::OP_DELETE_MAX) ? (rd_data_ff > best_ff)
                                                            : (best_ff > rd_data_ff);
      stat.rsp_hold     = rsp_valid_ff & ~rsp_ready;
   end

endmodule

@@ rtl/array_priority_queue_core.sv @@
// array_priority_queue_core: top level of the array priority queue
// depends on apq_pkg, apq_if, apq_ctrl and apq_dp
//
// Usage: each request beat on req_chan carries one command (opcode, value);
// each command yields exactly one response beat on rsp_chan with status,
// removed word, removed slot and the occupancy after the command.
// One command is worked at a time. The request side is ready only while the
// sequencer is idle; the entry store has one read and one write port with
// registered read data, so each entry visited takes a read step and then a step that uses the read data.
// Work per command:
//   plain insert, rejected insert or delete, unused opcode: settled at decode
//   sorted insert: entries move one slot toward the rear, from the rear on, until the new word fits
//   delete front: the front entry is taken and the front advances
//   delete max or min: every entry past the front is scanned, then the entries
//   between the front and the hit shift one slot toward the rear
// A new request is taken the cycle after the response is loaded.
// The response sits in an output register; if the receiver stalls, the next
// command is still taken and worked, and waits at its end until that
// register frees. Reset empties the queue (both pointers to slot 0) and
// drops any pending response; stored words need no clearing.
module array_priority_queue_core (
   input logic        clock,
   input logic        reset,
   apq_req_if.sink    req_chan,
   apq_rsp_if.source  rsp_chan
);

   apq_pkg::cmd_type  cmd;
   apq_pkg::stat_type stat;

   apq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   apq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_chan.opcode),
      .req_value         (req_chan.value),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_status        (rsp_chan.status),
      .rsp_removed_value (rsp_chan.removed_value),
      .rsp_removed_index (rsp_chan.removed_index),
      .rsp_occupancy     (rsp_chan.occupancy)
   );

endmodule
